// ----- design/brp_pkg.sv -----
package brp_pkg;

    localparam int TICK_W    = 48;
    localparam int SEC_W     = 32;
    localparam int OBJ_CNT_W = 17;
    localparam int OBJ_IDX_W = 16;
    localparam int ICNT_W    = 5;
    localparam int BCNT_W    = 4;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam int BURST_LEN_DEF      = 10;
    localparam int SCHEDULE_DEPTH_DEF = 16;
    localparam int MAX_OBJECTS_DEF    = 65536;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_WRITE   = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_OBJECTS   = 1'b0,
        CFG_NUM_INTERVALS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind              kind;
        logic [TICK_W-1:0]  now_ticks;
        logic [SEC_W-1:0]   now_seconds;
        logic [SLOT_W-1:0]  entry_slot;
        logic [TICK_W-1:0]  entry_burst_ticks;
        logic [SEC_W-1:0]   entry_duration_secs;
    } t_in_item;

    typedef struct packed {
        logic                  granted;
        logic [OBJ_IDX_W-1:0]  object_index;
        logic                  throttled;
        logic                  finished;
    } t_out_item;

    // one schedule table write
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [TICK_W-1:0]  period;
        logic [SEC_W-1:0]   duration;
    } t_sched_wr;

endpackage

// ----- design/brp_sched.sv -----
module brp_sched #(
    parameter int SCHEDULE_DEPTH = brp_pkg::SCHEDULE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  brp_pkg::t_sched_wr          i_wr,
    input  logic [brp_pkg::ICNT_W-1:0]  i_rd_sel,
    output logic [brp_pkg::TICK_W-1:0]  o_period,
    output logic [brp_pkg::SEC_W-1:0]   o_duration
);
    import brp_pkg::*;

    localparam int AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;

    logic [TICK_W-1:0] r_period [SCHEDULE_DEPTH];
    logic [SEC_W-1:0]  r_duration [SCHEDULE_DEPTH];

    // slots past the table depth are dropped
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.slot) < SCHEDULE_DEPTH)) begin
            r_period[i_wr.slot[AW-1:0]]   <= i_wr.period;
            r_duration[i_wr.slot[AW-1:0]] <= i_wr.duration;
        end
    end

    always_comb begin
        if (32'(i_rd_sel) < SCHEDULE_DEPTH) begin
            o_period   = r_period[i_rd_sel[AW-1:0]];
            o_duration = r_duration[i_rd_sel[AW-1:0]];
        end else begin
            o_period   = '0;
            o_duration = '0;
        end
    end

endmodule

// ----- design/burst_rate_pacer.sv -----
// datapath: an accepted input beat goes through the input register, then the result
//   register, to the output; one beat in, one beat out
// throughput: one item per cycle unless the output stalls; pacing state is updated in
//   the same cycle the item leaves the input register, so the next item sees it at once
// reset: synchronous, active low; clears pacing state and sets num_objects to 1 and
//   num_intervals to 0; the schedule table keeps its contents and must be written
module burst_rate_pacer #(
    parameter int BURST_LEN      = brp_pkg::BURST_LEN_DEF,
    parameter int SCHEDULE_DEPTH = brp_pkg::SCHEDULE_DEPTH_DEF,
    parameter int MAX_OBJECTS    = brp_pkg::MAX_OBJECTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  brp_pkg::t_in_item               i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output brp_pkg::t_out_item              o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [brp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [brp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import brp_pkg::*;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // handshake
    logic      r_in_valid, r_out_valid;
    t_in_item  r_in;
    t_out_item r_out, n_out;
    logic      w_out_take, w_proc, w_in_acc;

    // configuration
    logic [OBJ_CNT_W-1:0] r_num_objects;
    logic [ICNT_W-1:0]    r_num_intervals;
    logic [OBJ_CNT_W-1:0] w_eff_objects;
    logic [ICNT_W-1:0]    w_eff_intervals;

    // pacing state
    logic                 r_started, n_started;
    logic [OBJ_CNT_W-1:0] r_next_object, n_next_object;
    logic [ICNT_W-1:0]    r_cur_interval, n_cur_interval;
    logic [BCNT_W-1:0]    r_burst_count, n_burst_count;
    logic [TICK_W-1:0]    r_burst_ref, n_burst_ref;
    logic [TICK_W-1:0]    r_next_burst, n_next_burst;
    logic [TICK_W-1:0]    r_credit, n_credit;
    logic [SEC_W-1:0]     r_start_sec, n_start_sec;

    // schedule table
    t_sched_wr         w_wr;
    logic [TICK_W-1:0] w_sleep;
    logic [SEC_W-1:0]  w_duration;

    // datapath
    logic [TICK_W-1:0]    w_now;
    logic [SEC_W-1:0]     w_sec, w_start;
    logic [TICK_W-1:0]    w_ref_eff, w_elapsed, w_credit_acc, w_credit_rest;
    logic [TICK_W-1:0]    w_sleep_left, w_deadline, w_late_credit;
    logic [TICK_W:0]      w_sum_acc, w_sum_deadline, w_sum_late;
    logic                 w_credit_ok, w_deadline_hit, w_interval_done;
    logic [OBJ_CNT_W-1:0] w_obj;
    logic                 w_wait;
    logic [BCNT_W-1:0]    w_bc;

    assign w_out_take = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_take;
    assign o_in_stall = r_in_valid && !w_out_take;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_in_acc || (r_in_valid && !w_proc);
            r_out_valid <= w_proc || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_objects   <= OBJ_CNT_W'(1);
            r_num_intervals <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_NUM_OBJECTS: begin
                    r_num_objects <= i_cfg_wdata[OBJ_CNT_W-1:0];
                end
                CFG_NUM_INTERVALS: begin
                    r_num_intervals <= i_cfg_wdata[ICNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_num_objects == '0) begin
            w_eff_objects = OBJ_CNT_W'(1);
        end else if (32'(r_num_objects) > MAX_OBJECTS) begin
            w_eff_objects = OBJ_CNT_W'(MAX_OBJECTS);
        end else begin
            w_eff_objects = r_num_objects;
        end
    end

    assign w_eff_intervals = (32'(r_num_intervals) > SCHEDULE_DEPTH) ?
                             ICNT_W'(SCHEDULE_DEPTH) : r_num_intervals;

    assign w_wr.en       = w_proc && (r_in.kind == KIND_WRITE);
    assign w_wr.slot     = r_in.entry_slot;
    assign w_wr.period   = r_in.entry_burst_ticks;
    assign w_wr.duration = r_in.entry_duration_secs;

    brp_sched #(
        .SCHEDULE_DEPTH(SCHEDULE_DEPTH)
    ) u_sched (
        .i_clk      (i_clk),
        .i_wr       (w_wr),
        .i_rd_sel   (r_cur_interval),
        .o_period   (w_sleep),
        .o_duration (w_duration)
    );

    assign w_now   = r_in.now_ticks;
    assign w_sec   = r_in.now_seconds;
    assign w_start = r_started ? r_start_sec : w_sec;

    // fresh deadline: lateness since the burst reference goes into the credit
    assign w_ref_eff      = (r_burst_ref == '0) ? w_now : r_burst_ref;
    assign w_elapsed      = (w_now >= w_ref_eff) ? (w_now - w_ref_eff) : '0;
    assign w_sum_acc      = {1'b0, r_credit} + {1'b0, w_elapsed};
    assign w_credit_acc   = w_sum_acc[TICK_W] ? TICK_MAX : w_sum_acc[TICK_W-1:0];
    assign w_credit_ok    = (w_credit_acc >= w_sleep);
    assign w_credit_rest  = w_credit_acc - w_sleep;
    assign w_sleep_left   = w_sleep - w_credit_acc;
    assign w_sum_deadline = {1'b0, w_now} + {1'b0, w_sleep_left};
    assign w_deadline     = w_sum_deadline[TICK_W] ? TICK_MAX : w_sum_deadline[TICK_W-1:0];

    // pending deadline: overshoot past it is credited
    assign w_deadline_hit = (w_now >= r_next_burst);
    assign w_sum_late     = {1'b0, r_credit} + {1'b0, w_now - r_next_burst};
    assign w_late_credit  = w_sum_late[TICK_W] ? TICK_MAX : w_sum_late[TICK_W-1:0];

    assign w_interval_done = (w_sec >= w_start) && ((w_sec - w_start) >= w_duration);
    assign w_obj = (r_next_object >= w_eff_objects) ? '0 : r_next_object;

    always_comb begin
        n_started      = r_started;
        n_next_object  = r_next_object;
        n_cur_interval = r_cur_interval;
        n_burst_count  = r_burst_count;
        n_burst_ref    = r_burst_ref;
        n_next_burst   = r_next_burst;
        n_credit       = r_credit;
        n_start_sec    = r_start_sec;
        n_out          = '0;
        w_wait         = 1'b0;
        w_bc           = r_burst_count;
        if (w_proc && (r_in.kind == KIND_REQUEST)) begin
            n_started     = 1'b1;
            n_start_sec   = w_start;
            n_next_object = w_obj;
            if (r_cur_interval < w_eff_intervals) begin
                if (r_burst_count >= BCNT_W'(BURST_LEN)) begin
                    if (r_next_burst == '0) begin
                        priority if (w_credit_ok) begin
                            n_credit     = w_credit_rest;
                            w_bc         = '0;
                            n_burst_ref  = w_now;
                            n_next_burst = '0;
                        end else if (w_now == TICK_MAX) begin
                            // saturated deadline is already reached
                            n_credit     = '0;
                            w_bc         = '0;
                            n_burst_ref  = w_now;
                            n_next_burst = '0;
                        end else begin
                            w_wait       = 1'b1;
                            n_credit     = '0;
                            n_burst_ref  = w_ref_eff;
                            n_next_burst = w_deadline;
                        end
                    end else if (w_deadline_hit) begin
                        n_credit     = w_late_credit;
                        w_bc         = '0;
                        n_burst_ref  = w_now;
                        n_next_burst = '0;
                    end else begin
                        w_wait = 1'b1;
                    end
                end
                if (w_wait) begin
                    n_out.throttled = 1'b1;
                end else begin
                    n_burst_count = w_bc + BCNT_W'(1);
                    if (w_interval_done) begin
                        n_start_sec    = w_sec;
                        n_cur_interval = r_cur_interval + ICNT_W'(1);
                        n_credit       = '0;
                    end
                    n_out.granted      = 1'b1;
                    n_out.object_index = w_obj[OBJ_IDX_W-1:0];
                    n_next_object      = w_obj + OBJ_CNT_W'(1);
                end
            end
        end
        n_out.finished = (n_cur_interval >= w_eff_intervals);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_next_object  <= '0;
            r_cur_interval <= '0;
            r_burst_count  <= '0;
            r_burst_ref    <= '0;
            r_next_burst   <= '0;
            r_credit       <= '0;
            r_start_sec    <= '0;
        end else begin
            r_started      <= n_started;
            r_next_object  <= n_next_object;
            r_cur_interval <= n_cur_interval;
            r_burst_count  <= n_burst_count;
            r_burst_ref    <= n_burst_ref;
            r_next_burst   <= n_next_burst;
            r_credit       <= n_credit;
            r_start_sec    <= n_start_sec;
        end
    end

    // a pending deadline only exists while a full burst waits
    a_deadline_needs_full_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_burst != '0) |-> (r_burst_count >= BCNT_W'(BURST_LEN)))
        else $error("deadline set without a full burst");

    a_burst_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_count <= BCNT_W'(BURST_LEN))
        else $error("burst count past burst length");

    a_interval_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur_interval) <= SCHEDULE_DEPTH)
        else $error("interval index past schedule depth");

    a_grant_xor_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.granted && o_out_data.throttled))
        else $error("beat both granted and throttled");

endmodule
